@@ hdl/cimd_pkg.sv @@
package cimd_pkg;

	// request codes
	localparam logic [1:0] REQ_MASK     = 2'd0;
	localparam logic [1:0] REQ_UNMASK   = 2'd1;
	localparam logic [1:0] REQ_CLEAR    = 2'd2;
	localparam logic [1:0] REQ_DISPATCH = 2'd3;

	// register write targets
	localparam logic [2:0] TGT_NONE     = 3'd0;
	localparam logic [2:0] TGT_PRI_ENA  = 3'd1;
	localparam logic [2:0] TGT_PRI_CLR  = 3'd2;
	localparam logic [2:0] TGT_SEC_A    = 3'd3;
	localparam logic [2:0] TGT_SEC_B    = 3'd4;

	// source numbering
	localparam int PRI_COUNT   = 14;
	localparam int SEC_COUNT   = 5;
	localparam int TOTAL_COUNT = 24;
	localparam int MUX_A_BIT   = 3;
	localparam int MUX_B_BIT   = 13;
	localparam int LEVEL_COUNT = 6;

	localparam logic [15:0] PRI_SET_BIT = 16'h8000;
	localparam logic [7:0]  SEC_SET_BIT = 8'h80;
	localparam logic [7:0]  SEC_PEND_MASK = 8'h1F;

	// primary bits routed to each CPU level (levels 1..6, entry 0 is level 1)
	localparam logic [LEVEL_COUNT-1:0][15:0] LEVEL_MAP = {
		16'h2000, 16'h1800, 16'h0780, 16'h0070, 16'h300C, 16'h0007
	};

	typedef struct packed {
		logic [1:0]  req_type;
		logic [4:0]  irq;
		logic [2:0]  cpu_level;
		logic [15:0] primary_pending;
		logic [15:0] primary_enabled;
		logic [7:0]  sec_a_status;
		logic [7:0]  sec_b_status;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [2:0]  write_target;
		logic [15:0] write_value;
		logic        source_valid;
		logic [4:0]  source_irq;
		logic        last;
	} rsp_t;

endpackage

@@ hdl/cascaded_irq_mask_and_dispatch.sv @@
// Cascaded interrupt mask and dispatch. Serves 24 sources: 1..14 are primary
// controller bits 0..13, 15..19 sit on secondary A (cascaded on primary bit 3),
// 20..24 on secondary B (cascaded on primary bit 13). Mask, unmask and clear
// requests each return one result holding the register write a driver would
// issue; mask/unmask also track the secondary enable masks. A dispatch request
// at CPU level 1..6 returns one result per pending source in ascending order,
// the last one carrying the primary pending-clear write for the cascade bits;
// with nothing pending it returns a single result with source_valid low.
// Levels 0 and 7 return nothing. Timing: a request is taken in the idle state
// and decoded in the next cycle; mask/unmask/clear results then load into the
// output register once it is free. For a dispatch, one shared lowest-set-bit
// encoder walks the 24-bit pending vector, one source per cycle while the
// output is not stalled. The output register lets the next request be taken
// while the previous result still waits; a stalled output holds the
// sequencer.
module cascaded_irq_mask_and_dispatch
	import cimd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]  state_q;
	req_t        req_q;
	logic [4:0]  sec_a_en_q;
	logic [4:0]  sec_b_en_q;
	logic [23:0] pend_q;      // remaining sources to list, bit i = source i+1
	logic [15:0] clr_q;       // pending-clear word for the cascade bits
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	// output slot can take a new result this cycle
	logic out_free;
	// a new result enters the output register this cycle
	logic rsp_load;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_load  = out_free && (state_q == ST_EMIT
		|| (state_q == ST_CALC && req_q.req_type != REQ_DISPATCH));
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---- decode of the held request ----
	logic        irq_bad;
	logic        irq_pri;
	logic        irq_sec_a;
	logic [3:0]  pri_bit;
	logic [2:0]  sec_bit;
	logic [15:0] pri_onehot;
	logic [7:0]  sec_onehot;
	logic        is_set;

	always_comb begin
		irq_bad    = (req_q.irq == 5'd0) || (req_q.irq > 5'(TOTAL_COUNT));
		irq_pri    = (req_q.irq <= 5'(PRI_COUNT));
		irq_sec_a  = (req_q.irq <= 5'(PRI_COUNT + SEC_COUNT));
		pri_bit    = 4'(req_q.irq - 5'd1);
		if (irq_sec_a) begin
			sec_bit = 3'(req_q.irq - 5'(PRI_COUNT + 1));
		end else begin
			sec_bit = 3'(req_q.irq - 5'(PRI_COUNT + SEC_COUNT + 1));
		end
		pri_onehot = 16'h0001 << pri_bit;
		sec_onehot = 8'h01 << sec_bit;
		is_set     = (req_q.req_type == REQ_UNMASK);
	end

	// single result of a mask, unmask or clear request
	rsp_t calc_rsp;

	always_comb begin
		calc_rsp = '{status: 1'b0, write_target: TGT_NONE, write_value: 16'd0,
			source_valid: 1'b0, source_irq: 5'd0, last: 1'b1};
		if (irq_bad) begin
			calc_rsp.status = 1'b1;
		end else if (req_q.req_type == REQ_CLEAR) begin
			if (irq_pri) begin
				calc_rsp.write_target = TGT_PRI_CLR;
				calc_rsp.write_value  = pri_onehot;
			end
		end else if (irq_pri) begin
			calc_rsp.write_target = TGT_PRI_ENA;
			calc_rsp.write_value  = pri_onehot | (is_set ? PRI_SET_BIT : 16'd0);
		end else begin
			calc_rsp.write_target = irq_sec_a ? TGT_SEC_A : TGT_SEC_B;
			calc_rsp.write_value  = {8'd0, sec_onehot | (is_set ? SEC_SET_BIT : 8'd0)};
		end
	end

	// ---- dispatch preparation: level filter and cascade expansion ----
	logic        lvl_ok;
	logic [15:0] here;
	logic [4:0]  en_a;
	logic [4:0]  en_b;
	logic [23:0] comb;
	logic [15:0] clr_word;

	always_comb begin
		lvl_ok = (req_q.cpu_level != 3'd0) && (req_q.cpu_level != 3'd7);
		here   = req_q.primary_pending & req_q.primary_enabled
			& LEVEL_MAP[3'(req_q.cpu_level - 3'd1)];
		en_a   = req_q.sec_a_status[4:0] & SEC_PEND_MASK[4:0] & sec_a_en_q;
		en_b   = req_q.sec_b_status[4:0] & SEC_PEND_MASK[4:0] & sec_b_en_q;
		comb   = {10'd0, here[13:0]};
		comb[MUX_A_BIT] = 1'b0;
		comb[MUX_B_BIT] = 1'b0;
		clr_word = 16'd0;
		if (here[MUX_A_BIT]) begin
			if (req_q.sec_a_status[7] && (en_a != 5'd0)) begin
				comb[PRI_COUNT +: SEC_COUNT] = en_a;
			end
			clr_word[MUX_A_BIT] = 1'b1;
		end
		if (here[MUX_B_BIT]) begin
			if (req_q.sec_b_status[7] && (en_b != 5'd0)) begin
				comb[PRI_COUNT + SEC_COUNT +: SEC_COUNT] = en_b;
			end
			clr_word[MUX_B_BIT] = 1'b1;
		end
	end

	// ---- shared lowest-set-bit encoder ----
	logic [4:0]  low_idx;
	logic [23:0] pend_rest;
	logic        pend_fin;

	always_comb begin
		low_idx = 5'd0;
		for (int i = TOTAL_COUNT - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				low_idx = 5'(i);
			end
		end
		pend_rest = pend_q & (pend_q - 24'd1);
		pend_fin  = (pend_rest == 24'd0);
	end

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			sec_a_en_q  <= 5'd0;
			sec_b_en_q  <= 5'd0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (req_q.req_type == REQ_DISPATCH) begin
						state_q <= lvl_ok ? ST_EMIT : ST_IDLE;
					end else if (out_free) begin
						state_q <= ST_IDLE;
						if ((req_q.req_type == REQ_MASK || req_q.req_type == REQ_UNMASK)
							&& !irq_bad && !irq_pri) begin
							if (irq_sec_a) begin
								sec_a_en_q <= is_set ? (sec_a_en_q | sec_onehot[4:0])
									: (sec_a_en_q & ~sec_onehot[4:0]);
							end else begin
								sec_b_en_q <= is_set ? (sec_b_en_q | sec_onehot[4:0])
									: (sec_b_en_q & ~sec_onehot[4:0]);
							end
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (pend_q == 24'd0 || pend_fin) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == ST_CALC) begin
			pend_q <= comb;
			clr_q  <= clr_word;
			if (req_q.req_type != REQ_DISPATCH && out_free) begin
				rsp_q <= calc_rsp;
			end
		end
		if (state_q == ST_EMIT && out_free) begin
			pend_q <= pend_rest;
			rsp_q.status       <= 1'b0;
			rsp_q.source_valid <= (pend_q != 24'd0);
			rsp_q.source_irq   <= (pend_q != 24'd0) ? (low_idx + 5'd1) : 5'd0;
			rsp_q.last         <= (pend_q == 24'd0) || pend_fin;
			if ((pend_q == 24'd0 || pend_fin) && (clr_q != 16'd0)) begin
				rsp_q.write_target <= TGT_PRI_CLR;
				rsp_q.write_value  <= clr_q;
			end else begin
				rsp_q.write_target <= TGT_NONE;
				rsp_q.write_value  <= 16'd0;
			end
		end
	end

endmodule

@@ dv/cimd_checker.sv @@
`timescale 1ns / 100ps

module cimd_checker
	import cimd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   mismatches,
	output int   results_owed
);

	logic [4:0] sec_a_en;
	logic [4:0] sec_b_en;
	rsp_t       irq_results_due [$];
	int         fault_tally;

	// expected results of one request; tracks the secondary enable masks
	task automatic work_out_irq_results(input req_t r);
		rsp_t        o;
		logic [15:0] here;
		logic [15:0] clr_word;
		logic [23:0] srcs;
		logic [4:0]  en;
		logic [2:0]  clr_tgt;
		int          s;
		int          b;
		int          lvl;
		o = '0;
		o.last = 1'b1;
		s = r.irq;
		lvl = r.cpu_level;
		case (r.req_type) inside
			REQ_MASK, REQ_UNMASK: begin
				if (s < 1 || s > TOTAL_COUNT) begin
					o.status = 1'b1;
				end else if (s <= PRI_COUNT) begin
					o.write_target = TGT_PRI_ENA;
					o.write_value = 16'd1 << (s - 1);
					if (r.req_type == REQ_UNMASK)
						o.write_value |= PRI_SET_BIT;
				end else begin
					// sources 15..19 sit on A (19 included), 20..24 on B
					if (s <= PRI_COUNT + SEC_COUNT) begin
						b = s - PRI_COUNT - 1;
						o.write_target = TGT_SEC_A;
						if (r.req_type == REQ_UNMASK)
							sec_a_en[b] = 1'b1;
						else
							sec_a_en[b] = 1'b0;
					end else begin
						b = s - PRI_COUNT - SEC_COUNT - 1;
						o.write_target = TGT_SEC_B;
						if (r.req_type == REQ_UNMASK)
							sec_b_en[b] = 1'b1;
						else
							sec_b_en[b] = 1'b0;
					end
					o.write_value = {8'h00, 8'd1 << b};
					if (r.req_type == REQ_UNMASK)
						o.write_value |= {8'h00, SEC_SET_BIT};
				end
				irq_results_due.push_back(o);
			end
			REQ_CLEAR: begin
				if (s < 1 || s > TOTAL_COUNT) begin
					o.status = 1'b1;
				end else if (s <= PRI_COUNT) begin
					o.write_target = TGT_PRI_CLR;
					o.write_value = 16'd1 << (s - 1);
				end
				// secondary source: reading its status already cleared it
				irq_results_due.push_back(o);
			end
			default: begin
				if (lvl >= 1 && lvl <= LEVEL_COUNT) begin
					here = r.primary_pending & r.primary_enabled & LEVEL_MAP[lvl - 1];
					srcs = {10'd0, here[13:0]};
					srcs[MUX_A_BIT] = 1'b0;
					srcs[MUX_B_BIT] = 1'b0;
					clr_word = '0;
					if (here[MUX_A_BIT]) begin
						en = r.sec_a_status[4:0] & sec_a_en;
						if (r.sec_a_status[7] && en != 0)
							srcs[18:14] = en;
						clr_word[MUX_A_BIT] = 1'b1;
					end
					if (here[MUX_B_BIT]) begin
						en = r.sec_b_status[4:0] & sec_b_en;
						if (r.sec_b_status[7] && en != 0)
							srcs[23:19] = en;
						clr_word[MUX_B_BIT] = 1'b1;
					end
					clr_tgt = (clr_word != 0) ? TGT_PRI_CLR : TGT_NONE;
					if (srcs == 0) begin
						o.write_target = clr_tgt;
						o.write_value = clr_word;
						irq_results_due.push_back(o);
					end else begin
						for (int i = 0; i < TOTAL_COUNT; i++) begin
							if (srcs[i]) begin
								o = '0;
								o.source_valid = 1'b1;
								o.source_irq = 5'(i + 1);
								if ((srcs >> (i + 1)) == 0) begin
									o.last = 1'b1;
									o.write_target = clr_tgt;
									o.write_value = clr_word;
								end
								irq_results_due.push_back(o);
							end
						end
					end
				end
			end
		endcase
	endtask

	task automatic compare_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			fault_tally++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			sec_a_en = '0;
			sec_b_en = '0;
			irq_results_due.delete();
			fault_tally = 0;
			mismatches <= 0;
			results_owed <= 0;
		end else begin
			if (req_valid && req_ready)
				work_out_irq_results(req);
			if (rsp_valid && rsp_ready) begin
				if (irq_results_due.size() == 0) begin
					fault_tally++;
					$display("%0t: unexpected result, expected none, actual %p", $time, rsp);
				end else begin
					want = irq_results_due.pop_front();
					compare_field("status", want.status, rsp.status);
					compare_field("write_target", want.write_target, rsp.write_target);
					compare_field("write_value", want.write_value, rsp.write_value);
					compare_field("source_valid", want.source_valid, rsp.source_valid);
					compare_field("source_irq", want.source_irq, rsp.source_irq);
					compare_field("last", want.last, rsp.last);
				end
			end
			mismatches <= fault_tally;
			results_owed <= irq_results_due.size();
		end
	end

endmodule

@@ dv/tb_cascaded_irq_mask_and_dispatch.sv @@
`timescale 1ns / 100ps

// Stimulus and verdict for the cascaded interrupt mask/dispatch block.
// The checker instance beside the DUT predicts and compares every result.
module tb_cascaded_irq_mask_and_dispatch;
	import cimd_pkg::*;

	// worst run: ~180 requests x 12 results x the longest stall, taken ~10x over
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 145;
	localparam int DRAIN_CYCLES = 30;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	int mismatches;
	int results_owed;
	int cycle_count = 0;
	bit calm;   // when set, neither side idles

	cascaded_irq_mask_and_dispatch dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	cimd_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp          (rsp),
		.mismatches   (mismatches),
		.results_owed (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the DUT hangs or drops results.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL cascaded_irq_mask_and_dispatch");
			$finish;
		end
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic req_t irq_request(input logic [1:0] kind, input logic [4:0] src,
			input logic [2:0] lvl, input logic [15:0] pend, input logic [15:0] ena,
			input logic [7:0] sa, input logic [7:0] sb);
		req_t r;
		r.req_type = kind;
		r.irq = src;
		r.cpu_level = lvl;
		r.primary_pending = pend;
		r.primary_enabled = ena;
		r.sec_a_status = sa;
		r.sec_b_status = sb;
		return r;
	endfunction

	// Random request. Dispatch-heavy with mostly legal sources and levels, so
	// the cascade paths get exercised; unmask outweighs mask so that the
	// secondary enables stay mostly populated.
	function automatic req_t random_irq_request();
		req_t r;
		int   pick;
		r = '0;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			r.req_type = REQ_DISPATCH;
		else if (pick < 70)
			r.req_type = REQ_UNMASK;
		else if (pick < 85)
			r.req_type = REQ_MASK;
		else
			r.req_type = REQ_CLEAR;
		// out-of-range source about one time in ten: 0 or 25..31
		if ($urandom_range(0, 9) == 0) begin
			r.irq = 5'($urandom_range(24, 31));
			if (r.irq == 5'd24)
				r.irq = 5'd0;
		end else begin
			r.irq = 5'($urandom_range(1, TOTAL_COUNT));
		end
		if ($urandom_range(0, 9) == 0)
			r.cpu_level = ($urandom_range(0, 1) != 0) ? 3'd7 : 3'd0;
		else
			r.cpu_level = 3'($urandom_range(1, LEVEL_COUNT));
		r.primary_pending = 16'($urandom);
		r.primary_enabled = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
		r.sec_a_status = 8'($urandom);
		r.sec_b_status = 8'($urandom);
		// status "any" bit usually set so the secondaries get expanded
		if ($urandom_range(0, 3) != 0)
			r.sec_a_status[7] = 1'b1;
		if ($urandom_range(0, 3) != 0)
			r.sec_b_status[7] = 1'b1;
		return r;
	endfunction

	// Present one request and hold it until the DUT takes it. valid is only
	// dropped when a gap follows, so it is never lowered and raised in one step.
	task automatic issue_irq_request(input req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	// Response side: ready bursts separated by random stalls.
	initial begin
		int stall;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin
		req_t r;
		int   counted;
		calm = 1'b0;
		arst_n = 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// out-of-range sources: status error, no write
		issue_irq_request(irq_request(REQ_MASK, 5'd0, 3'd0, '0, '0, '0, '0));
		issue_irq_request(irq_request(REQ_UNMASK, 5'd25, 3'd0, '0, '0, '0, '0));
		issue_irq_request(irq_request(REQ_UNMASK, 5'd31, 3'd0, '0, '0, '0, '0));
		// primary enable writes at both ends of the primary range
		issue_irq_request(irq_request(REQ_UNMASK, 5'd1, 3'd0, '0, '0, '0, '0));
		issue_irq_request(irq_request(REQ_UNMASK, 5'd14, 3'd0, '0, '0, '0, '0));
		issue_irq_request(irq_request(REQ_MASK, 5'd14, 3'd0, '0, '0, '0, '0));
		// secondary enables; source nineteen lands on the first secondary
		issue_irq_request(irq_request(REQ_UNMASK, 5'd15, 3'd0, '0, '0, '0, '0));
		issue_irq_request(irq_request(REQ_UNMASK, 5'd19, 3'd0, '0, '0, '0, '0));
		issue_irq_request(irq_request(REQ_UNMASK, 5'd20, 3'd0, '0, '0, '0, '0));
		issue_irq_request(irq_request(REQ_UNMASK, 5'd24, 3'd0, '0, '0, '0, '0));
		// clears: primary extremes, secondary (no write), invalid
		issue_irq_request(irq_request(REQ_CLEAR, 5'd1, 3'd0, '0, '0, '0, '0));
		issue_irq_request(irq_request(REQ_CLEAR, 5'd14, 3'd0, '0, '0, '0, '0));
		issue_irq_request(irq_request(REQ_CLEAR, 5'd15, 3'd0, '0, '0, '0, '0));
		issue_irq_request(irq_request(REQ_CLEAR, 5'd0, 3'd0, '0, '0, '0, '0));
		// unused levels give no result at all
		issue_irq_request(irq_request(REQ_DISPATCH, 5'd0, 3'd0, 16'hFFFF, 16'hFFFF,
			8'hFF, 8'hFF));
		issue_irq_request(irq_request(REQ_DISPATCH, 5'd31, 3'd7, 16'hFFFF, 16'hFFFF,
			8'hFF, 8'hFF));
		// every level with everything pending; level 2 and 6 hit the cascades
		for (int lv = 1; lv <= LEVEL_COUNT; lv++)
			issue_irq_request(irq_request(REQ_DISPATCH, 5'd0, 3'(lv), 16'hFFFF, 16'hFFFF,
				8'hFF, 8'hFF));
		// nothing pending: single empty result
		issue_irq_request(irq_request(REQ_DISPATCH, 5'd0, 3'd1, 16'h0000, 16'hFFFF,
			8'hFF, 8'hFF));
		// cascade bits pending but secondaries report nothing: clear write only
		issue_irq_request(irq_request(REQ_DISPATCH, 5'd0, 3'd2, 16'h2008, 16'hFFFF,
			8'h1F, 8'h80));

		// --- random part ---
		// middle stretch runs without idling on either side
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			calm = (counted >= RANDOM_ITEMS / 3) && (counted < RANDOM_ITEMS / 2);
			r = random_irq_request();
			issue_irq_request(r);
			if (!(r.req_type == REQ_DISPATCH &&
					(r.cpu_level == 3'd0 || r.cpu_level == 3'd7)))
				counted++;
		end
		req_valid <= 1'b0;
		calm = 1'b1;

		// let the checker count the last request, drain, then give any stray
		// result time to show up
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS cascaded_irq_mask_and_dispatch");
		else
			$display("FAIL cascaded_irq_mask_and_dispatch");
		$finish;
	end

endmodule

@@ files.f @@
hdl/cimd_pkg.sv
hdl/cascaded_irq_mask_and_dispatch.sv
dv/cimd_checker.sv
dv/tb_cascaded_irq_mask_and_dispatch.sv
